[design/ccm_pkg.sv]
// ccm_pkg: shared constants, codes and calendar helpers for the cron
// calendar matcher. No dependencies.
package ccm_pkg;

  // table size default
  localparam int ENTRIES_DEF = 16;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int USED_W   = 5;
  localparam int WDAY_W   = 3;
  localparam int ENTRY_W  = 4;
  localparam int KIND_W   = 3;
  localparam int BITS_W   = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // mask widths
  localparam int MIN_MASK_W  = 60;
  localparam int HOUR_MASK_W = 24;
  localparam int MDAY_MASK_W = 31;
  localparam int MON_MASK_W  = 12;
  localparam int WDAY_MASK_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MONTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USED = 3'd5;

  // command and mask kind codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic [KIND_W-1:0] KIND_MINUTE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HOUR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MDAY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MONTH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WDAY   = 3'd4;

  // reciprocal multipliers: x/100 = (x*5243)>>19, x/7 = (x*37450)>>18
  // (exact for the operand ranges used here)
  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] RECIP100 = 16'd5243;
  localparam logic [MUL_B_W-1:0] RECIP7   = 16'd37450;
  localparam int SHIFT100 = 19;
  localparam int SHIFT7   = 18;

  // reset time
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd1970;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;

  // (3*(mm+1))/5 for mm in 0..15
  function automatic logic [3:0] mm_term(input logic [MONTH_W-1:0] mm);
    logic [3:0] t;
    unique case (mm)
      4'd0:  t = 4'd0;
      4'd1:  t = 4'd1;
      4'd2:  t = 4'd1;
      4'd3:  t = 4'd2;
      4'd4:  t = 4'd3;
      4'd5:  t = 4'd3;
      4'd6:  t = 4'd4;
      4'd7:  t = 4'd4;
      4'd8:  t = 4'd5;
      4'd9:  t = 4'd6;
      4'd10: t = 4'd6;
      4'd11: t = 4'd7;
      4'd12: t = 4'd7;
      4'd13: t = 4'd8;
      4'd14: t = 4'd9;
      4'd15: t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  // month length; invalid months count as 31 days
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[design/ccm_ram.sv]
// ccm_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module ccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cron_calendar_matcher.sv]
// cron_calendar_matcher: minute clock checked against a table of cron
// masks. Depends on ccm_pkg and ccm_ram.
//
// Usage:
//  - Input word: start is taken when busy is low. cmd = write loads one
//    mask of one entry in that same cycle; busy stays low, so another
//    word may follow at once.
//  - cmd = tick: busy rises for the whole run; N = entries in use (capped
//    at ENTRIES). States S_M1 to S_WD work out the weekday and leap flag through
//    one shared reciprocal multiplier (year/100, shifted year/100, sum
//    mod 7); then the N mask entries are read from the RAMs, one per cycle,
//    then a wait for the last registered read and a flush that advances the clock.
//  - Results: one word per matching entry, in entry order, each shown
//    for one cycle under hit_valid; last marks the final one. A result
//    is held back one match so last is known when it goes out. The
//    receiver cannot stall; results are never held.
//  - Config: cfg_we writes a register at once; writing any start field
//    reloads the whole clock. Write only while busy is low.
//  - Reset: clock back to 1970-01-01 00:00, registers to defaults, all
//    masks read as zero through per-entry valid bits (no clearing pass).
module cron_calendar_matcher
  import ccm_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [ENTRY_W-1:0]    entry,
  input  logic [KIND_W-1:0]     mask_kind,
  input  logic [BITS_W-1:0]     mask_bits,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // results
  output logic                  hit_valid,
  output logic [YEAR_W-1:0]     hit_year,
  output logic [MONTH_W-1:0]    hit_month,
  output logic [DAY_W-1:0]      hit_day,
  output logic [HOUR_W-1:0]     hit_hour,
  output logic [MINUTE_W-1:0]   hit_minute,
  output logic [WDAY_W-1:0]     hit_weekday,
  output logic [ENTRY_W-1:0]    hit_entry,
  output logic                  last
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;  // year / 100
  localparam logic [2:0] S_M2   = 3'd2;  // shifted year / 100
  localparam logic [2:0] S_SUM  = 3'd3;  // congruence sum
  localparam logic [2:0] S_M3   = 3'd4;  // sum / 7
  localparam logic [2:0] S_WD   = 3'd5;  // weekday and leap flag
  localparam logic [2:0] S_SCAN = 3'd6;  // one entry per cycle
  localparam logic [2:0] S_FIN  = 3'd7;  // flush, advance clock

  logic [2:0] state, state_next;

  // config registers and clock
  logic [YEAR_W-1:0]   reg_year,   reg_year_next;
  logic [MONTH_W-1:0]  reg_month,  reg_month_next;
  logic [DAY_W-1:0]    reg_day,    reg_day_next;
  logic [HOUR_W-1:0]   reg_hour,   reg_hour_next;
  logic [MINUTE_W-1:0] reg_minute, reg_minute_next;
  logic [USED_W-1:0]   reg_used,   reg_used_next;

  logic [YEAR_W-1:0]   clock_year,   clock_year_next;
  logic [MONTH_W-1:0]  clock_month,  clock_month_next;
  logic [DAY_W-1:0]    clock_day,    clock_day_next;
  logic [HOUR_W-1:0]   clock_hour,   clock_hour_next;
  logic [MINUTE_W-1:0] clock_minute, clock_minute_next;

  // weekday / leap datapath
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         q_y, q_yy;
  logic [11:0]        q_w;
  logic [MUL_A_W-1:0] w_sum, w_acc;
  logic [WDAY_W-1:0]  wd;
  logic               leap;
  logic               jan_feb;
  logic [MUL_A_W-1:0] yy;
  logic [MONTH_W-1:0] mm;
  logic [YEAR_W-1:0]  y_rem;
  logic [WDAY_W-1:0]  r7;

  // scan control
  logic [UW-1:0]      used;
  logic [UW-1:0]      idx;
  logic               issue;
  logic               rd_pend;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      raddr;
  logic               pend_hit;
  logic [ENTRY_W-1:0] pend_idx;
  logic               hit_now;

  // mask store
  logic               wr_ok;
  logic [AW-1:0]      waddr;
  logic               we_min, we_hour, we_mday, we_mon, we_wday;
  logic [ENTRIES-1:0] vld_min, vld_hour, vld_mday, vld_mon, vld_wday;
  logic               rv_min, rv_hour, rv_mday, rv_mon, rv_wday;
  logic [MIN_MASK_W-1:0]  rd_min;
  logic [HOUR_MASK_W-1:0] rd_hour;
  logic [MDAY_MASK_W-1:0] rd_mday;
  logic [MON_MASK_W-1:0]  rd_mon;
  logic [WDAY_MASK_W-1:0] rd_wday;

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // mask write decode
  assign wr_ok   = accept && (cmd == CMD_WRITE) && (int'(entry) < ENTRIES);
  assign waddr   = AW'(entry);
  assign we_min  = wr_ok && (mask_kind == KIND_MINUTE);
  assign we_hour = wr_ok && (mask_kind == KIND_HOUR);
  assign we_mday = wr_ok && (mask_kind == KIND_MDAY);
  assign we_mon  = wr_ok && (mask_kind == KIND_MONTH);
  assign we_wday = wr_ok && (mask_kind == KIND_WDAY);

  ccm_ram #(.WIDTH(MIN_MASK_W), .DEPTH(ENTRIES)) u_min_ram (
    .clk(clk), .we(we_min), .waddr(waddr), .wdata(mask_bits[MIN_MASK_W-1:0]),
    .raddr(raddr), .rdata(rd_min)
  );
  ccm_ram #(.WIDTH(HOUR_MASK_W), .DEPTH(ENTRIES)) u_hour_ram (
    .clk(clk), .we(we_hour), .waddr(waddr), .wdata(mask_bits[HOUR_MASK_W-1:0]),
    .raddr(raddr), .rdata(rd_hour)
  );
  ccm_ram #(.WIDTH(MDAY_MASK_W), .DEPTH(ENTRIES)) u_mday_ram (
    .clk(clk), .we(we_mday), .waddr(waddr), .wdata(mask_bits[MDAY_MASK_W-1:0]),
    .raddr(raddr), .rdata(rd_mday)
  );
  ccm_ram #(.WIDTH(MON_MASK_W), .DEPTH(ENTRIES)) u_mon_ram (
    .clk(clk), .we(we_mon), .waddr(waddr), .wdata(mask_bits[MON_MASK_W-1:0]),
    .raddr(raddr), .rdata(rd_mon)
  );
  ccm_ram #(.WIDTH(WDAY_MASK_W), .DEPTH(ENTRIES)) u_wday_ram (
    .clk(clk), .we(we_wday), .waddr(waddr), .wdata(mask_bits[WDAY_MASK_W-1:0]),
    .raddr(raddr), .rdata(rd_wday)
  );

  // valid bits: an unwritten mask reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_min  <= '0;
      vld_hour <= '0;
      vld_mday <= '0;
      vld_mon  <= '0;
      vld_wday <= '0;
    end else begin
      if (we_min)  vld_min[waddr]  <= 1'b1;
      if (we_hour) vld_hour[waddr] <= 1'b1;
      if (we_mday) vld_mday[waddr] <= 1'b1;
      if (we_mon)  vld_mon[waddr]  <= 1'b1;
      if (we_wday) vld_wday[waddr] <= 1'b1;
    end
  end

  // valid bits follow the registered RAM read
  always_ff @(posedge clk) begin
    rv_min  <= vld_min[raddr];
    rv_hour <= vld_hour[raddr];
    rv_mday <= vld_mday[raddr];
    rv_mon  <= vld_mon[raddr];
    rv_wday <= vld_wday[raddr];
  end

  // ---------------------------------------------------------------
  // shared reciprocal multiplier
  assign jan_feb = (clock_month == 4'd1) || (clock_month == 4'd2);
  assign yy = MUL_A_W'(clock_year) + MUL_A_W'(400) - (jan_feb ? MUL_A_W'(1) : '0);
  assign mm = jan_feb ? clock_month + 4'd12 : clock_month;

  always_comb begin
    unique case (state)
      S_M1:    mul_a = MUL_A_W'(clock_year);
      S_M2:    mul_a = yy;
      S_M3:    mul_a = w_acc;
      default: mul_a = '0;
    endcase
    mul_b = (state == S_M3) ? RECIP7 : RECIP100;
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // d + 2mm + 3(mm+1)/5 + yy + yy/4 + yy/400 - yy/100
  assign w_sum = MUL_A_W'(clock_day) + MUL_A_W'({mm, 1'b0}) + MUL_A_W'(mm_term(mm))
               + yy + (yy >> 2) + MUL_A_W'(q_yy >> 2) - MUL_A_W'(q_yy);

  assign y_rem = clock_year - YEAR_W'({6'd0, q_y} * 14'd100);
  assign r7    = WDAY_W'(w_acc - MUL_A_W'(q_w) * MUL_A_W'(7));

  always_ff @(posedge clk) begin
    unique case (state)
      S_M1:  q_y   <= 8'(prod >> SHIFT100);
      S_M2:  q_yy  <= 8'(prod >> SHIFT100);
      S_SUM: w_acc <= w_sum;
      S_M3:  q_w   <= 12'(prod >> SHIFT7);
      S_WD: begin
        wd   <= (r7 == 3'd6) ? 3'd0 : r7 + 3'd1;
        leap <= ((clock_year[1:0] == 2'd0) && (y_rem != '0))
             || ((y_rem == '0) && (q_y[1:0] == 2'd0));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // entry scan
  assign used  = (int'(reg_used) > ENTRIES) ? UW'(ENTRIES) : UW'(reg_used);
  assign issue = (state == S_SCAN) && (idx < used);
  assign raddr = idx[AW-1:0];

  // all five masks cover the current time
  always_comb begin
    hit_now = rd_pend
      && rv_min && (clock_minute < 6'd60) && rd_min[clock_minute]
      && rv_hour && (clock_hour < 5'd24) && rd_hour[clock_hour]
      && rv_mday && (clock_day != 5'd0) && rd_mday[clock_day - 5'd1]
      && rv_mon && (clock_month != 4'd0) && (clock_month <= 4'd12)
      && rd_mon[clock_month - 4'd1]
      && rv_wday && rd_wday[wd];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && (cmd == CMD_TICK)) state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_SUM;
      S_SUM:  state_next = S_M3;
      S_M3:   state_next = S_WD;
      S_WD:   state_next = S_SCAN;
      S_SCAN: if (!issue) state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_pend  <= 1'b0;
      pend_hit <= 1'b0;
      idx      <= '0;
    end else begin
      state <= state_next;
      if (state == S_WD) begin
        idx      <= '0;
        rd_pend  <= 1'b0;
        pend_hit <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_pend <= issue;
        if (issue) idx <= idx + UW'(1);
        if (hit_now) pend_hit <= 1'b1;
      end else begin
        rd_pend  <= 1'b0;
        pend_hit <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= raddr;
    if (hit_now) pend_idx <= ENTRY_W'(rd_idx);
  end

  // result word: a held match goes out when the next one turns up,
  // the final one at the flush with last set
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else begin
      hit_valid <= pend_hit && ((state == S_FIN) || (state == S_SCAN && hit_now));
    end
  end

  always_ff @(posedge clk) begin
    hit_year    <= clock_year;
    hit_month   <= clock_month;
    hit_day     <= clock_day;
    hit_hour    <= clock_hour;
    hit_minute  <= clock_minute;
    hit_weekday <= wd;
    hit_entry   <= pend_idx;
    last        <= (state == S_FIN);
  end

  // ---------------------------------------------------------------
  // config registers
  always_comb begin
    reg_year_next   = reg_year;
    reg_month_next  = reg_month;
    reg_day_next    = reg_day;
    reg_hour_next   = reg_hour;
    reg_minute_next = reg_minute;
    reg_used_next   = reg_used;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_YEAR:   reg_year_next   = cfg_data[YEAR_W-1:0];
        REG_START_MONTH:  reg_month_next  = cfg_data[MONTH_W-1:0];
        REG_START_DAY:    reg_day_next    = cfg_data[DAY_W-1:0];
        REG_START_HOUR:   reg_hour_next   = cfg_data[HOUR_W-1:0];
        REG_START_MINUTE: reg_minute_next = cfg_data[MINUTE_W-1:0];
        REG_ENTRIES_USED: reg_used_next   = cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // clock: reload on a start write, else advance one minute at the flush
  always_comb begin
    clock_year_next   = clock_year;
    clock_month_next  = clock_month;
    clock_day_next    = clock_day;
    clock_hour_next   = clock_hour;
    clock_minute_next = clock_minute;
    priority if (cfg_we && (cfg_index <= REG_START_MINUTE)) begin
      clock_year_next   = reg_year_next;
      clock_month_next  = reg_month_next;
      clock_day_next    = reg_day_next;
      clock_hour_next   = reg_hour_next;
      clock_minute_next = reg_minute_next;
    end else if (state == S_FIN) begin
      if (clock_minute < 6'd59) begin
        clock_minute_next = clock_minute + 6'd1;
      end else begin
        clock_minute_next = '0;
        if (clock_hour < 5'd23) begin
          clock_hour_next = clock_hour + 5'd1;
        end else begin
          clock_hour_next = '0;
          if (clock_day < month_days(clock_month, leap)) begin
            clock_day_next = clock_day + 5'd1;
          end else begin
            clock_day_next   = 5'd1;
            clock_month_next = 4'd1;
            if (clock_month >= 4'd12) begin
              clock_year_next = clock_year + 14'd1;
            end else if (clock_month != 4'd0) begin
              clock_month_next = clock_month + 4'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_year     <= RST_YEAR;
      reg_month    <= RST_MONTH;
      reg_day      <= RST_DAY;
      reg_hour     <= '0;
      reg_minute   <= '0;
      reg_used     <= '0;
      clock_year   <= RST_YEAR;
      clock_month  <= RST_MONTH;
      clock_day    <= RST_DAY;
      clock_hour   <= '0;
      clock_minute <= '0;
    end else begin
      reg_year     <= reg_year_next;
      reg_month    <= reg_month_next;
      reg_day      <= reg_day_next;
      reg_hour     <= reg_hour_next;
      reg_minute   <= reg_minute_next;
      reg_used     <= reg_used_next;
      clock_year   <= clock_year_next;
      clock_month  <= clock_month_next;
      clock_day    <= clock_day_next;
      clock_hour   <= clock_hour_next;
      clock_minute <= clock_minute_next;
    end
  end

endmodule
